// File: design/ssst_pkg.sv
`default_nettype none
package ssst_pkg;

  localparam int DATA_W          = 64;
  localparam int DEF_NUM_SHARDS  = 2;
  localparam int DEF_NUM_METRICS = 16;
  localparam int IN_DATA_W       = 80;
  localparam int OUT_DATA_W      = 6 * DATA_W;
  localparam int DIV_CNT_W       = 6;

  localparam logic [DATA_W-1:0] SMP_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SMP_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] mn;
    logic [DATA_W-1:0] mx;
    logic [DATA_W-1:0] last;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_RD_ISSUE,
    ST_RD_ACC,
    ST_DIV_LD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_en;
    logic rec_wr;
    logic acc_clr;
    logic acc_en;
    logic shard_rst;
    logic shard_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_is_read;
    logic in_metric_ok;
    logic shard_last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/ssst_ctrl.sv
`default_nettype none
module ssst_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  ssst_pkg::dp_status_t st,
  output ssst_pkg::dp_cmd_t    cmd
);
  import ssst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (st.in_is_read) begin
            cmd.acc_clr   = 1'b1;
            cmd.shard_rst = 1'b1;
            state_nxt     = st.in_metric_ok ? ST_RD_ISSUE : ST_DONE;
          end else if (st.in_metric_ok) begin
            state_nxt = ST_REC_RD;
          end
        end
      end
      ST_REC_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_REC_WR;
      end
      ST_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_RD_ACC;
      end
      ST_RD_ACC: begin
        cmd.acc_en     = 1'b1;
        cmd.shard_step = 1'b1;
        state_nxt      = st.shard_last ? ST_DIV_LD : ST_RD_ISSUE;
      end
      ST_DIV_LD: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/ssst_dp.sv
`default_nettype none
module ssst_dp #(
  parameter int NUM_SHARDS  = ssst_pkg::DEF_NUM_SHARDS,
  parameter int NUM_METRICS = ssst_pkg::DEF_NUM_METRICS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [ssst_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire                                in_tuser,
  input  ssst_pkg::dp_cmd_t                  cmd,
  output ssst_pkg::dp_status_t               st,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [ssst_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                         out_tuser
);
  import ssst_pkg::*;

  localparam int DEPTH   = NUM_METRICS * NUM_SHARDS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SHARD_W = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;

  entry_t mem [DEPTH];
  entry_t rd_q_r;

  // captured item
  logic [7:0]         metric_r;
  logic [SHARD_W-1:0] shard_r;
  logic [DATA_W-1:0]  sample_r;
  logic               ok_r;
  logic               is_read_r;

  logic [ADDR_W-1:0]  clr_idx_r;
  logic [SHARD_W-1:0] sidx_r;

  logic [7:0]         in_metric;
  logic [2:0]         in_core;
  logic [SHARD_W-1:0] in_shard;

  // merge accumulators
  logic [DATA_W-1:0] acc_cnt_r, acc_sum_r, acc_mn_r, acc_mx_r, acc_last_r;
  logic              acc_had_r;

  // divider
  logic [DATA_W-1:0]    dv_rem_r, dv_q_r, dv_d_r;
  logic                 dv_neg_r;
  logic [DIV_CNT_W-1:0] dv_cnt_r;
  logic [DATA_W:0]      dv_trial;
  logic [DATA_W:0]      dv_diff;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]        out_user_r;

  logic [ADDR_W-1:0] base_addr, wr_addr;
  logic              wr_en;
  entry_t            wr_data, rec_new;
  logic [DATA_W-1:0] mean_val;

  assign in_metric = in_tdata[7:0];
  assign in_core   = in_tdata[10:8];
  assign in_shard  = ({1'b0, in_core} < 4'(NUM_SHARDS)) ? SHARD_W'(in_core) : '0;

  assign st.clr_last     = (clr_idx_r == ADDR_W'(DEPTH - 1));
  assign st.in_is_read   = (in_tuser == CMD_READ);
  assign st.in_metric_ok = ({1'b0, in_metric} < 9'(NUM_METRICS));
  assign st.shard_last   = (sidx_r == SHARD_W'(NUM_SHARDS - 1));
  assign st.div_done     = (dv_cnt_r == DIV_CNT_W'(DATA_W - 1));
  assign st.out_free     = !out_valid_r || out_tready;

  assign base_addr = ADDR_W'(32'(metric_r) * NUM_SHARDS);

  always_comb begin
    rec_new.count = rd_q_r.count + DATA_W'(1);
    rec_new.sum   = rd_q_r.sum + sample_r;
    rec_new.last  = sample_r;
    rec_new.mn    = ($signed(sample_r) < $signed(rd_q_r.mn)) ? sample_r : rd_q_r.mn;
    rec_new.mx    = ($signed(sample_r) > $signed(rd_q_r.mx)) ? sample_r : rd_q_r.mx;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '{count: '0, sum: '0, mn: SMP_MAX, mx: SMP_MIN, last: '0};
    end else begin
      wr_en   = cmd.rec_wr;
      wr_addr = base_addr + ADDR_W'(shard_r);
      wr_data = rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[base_addr + ADDR_W'(is_read_r ? sidx_r : shard_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      metric_r  <= in_metric;
      shard_r   <= in_shard;
      sample_r  <= in_tdata[74:11];
      ok_r      <= st.in_metric_ok;
      is_read_r <= st.in_is_read;
    end
    if (cmd.shard_rst) begin
      sidx_r <= '0;
    end else if (cmd.shard_step && !st.shard_last) begin
      sidx_r <= sidx_r + SHARD_W'(1);
    end
    if (cmd.acc_clr) begin
      acc_cnt_r  <= '0;
      acc_sum_r  <= '0;
      acc_mn_r   <= SMP_MAX;
      acc_mx_r   <= SMP_MIN;
      acc_last_r <= '0;
      acc_had_r  <= 1'b0;
    end else if (cmd.acc_en && (rd_q_r.count != '0)) begin
      acc_cnt_r  <= acc_cnt_r + rd_q_r.count;
      acc_sum_r  <= acc_sum_r + rd_q_r.sum;
      if ($signed(rd_q_r.mn) < $signed(acc_mn_r)) acc_mn_r <= rd_q_r.mn;
      if ($signed(rd_q_r.mx) > $signed(acc_mx_r)) acc_mx_r <= rd_q_r.mx;
      acc_last_r <= rd_q_r.last;
      acc_had_r  <= 1'b1;
    end
  end

  // restoring divide on magnitudes, one quotient bit per cycle
  assign dv_trial = {dv_rem_r, dv_q_r[DATA_W-1]};
  assign dv_diff  = dv_trial - {1'b0, dv_d_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_rem_r <= '0;
      dv_q_r   <= acc_sum_r[DATA_W-1] ? (~acc_sum_r + DATA_W'(1)) : acc_sum_r;
      dv_d_r   <= acc_cnt_r[DATA_W-1] ? (~acc_cnt_r + DATA_W'(1)) : acc_cnt_r;
      dv_neg_r <= acc_sum_r[DATA_W-1] ^ acc_cnt_r[DATA_W-1];
      dv_cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!dv_diff[DATA_W]) begin
        dv_rem_r <= dv_diff[DATA_W-1:0];
        dv_q_r   <= {dv_q_r[DATA_W-2:0], 1'b1};
      end else begin
        dv_rem_r <= dv_trial[DATA_W-1:0];
        dv_q_r   <= {dv_q_r[DATA_W-2:0], 1'b0};
      end
      dv_cnt_r <= dv_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_comb begin
    if (!acc_had_r || (acc_cnt_r == '0)) begin
      mean_val = '0;
    end else begin
      mean_val = dv_neg_r ? (~dv_q_r + DATA_W'(1)) : dv_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_user_r <= {acc_had_r, ok_r};
      out_data_r <= {acc_last_r, mean_val,
                     acc_had_r ? acc_mx_r : DATA_W'(0),
                     acc_had_r ? acc_mn_r : DATA_W'(0),
                     acc_sum_r, acc_cnt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// File: design/sharded_sample_stats_table.sv
`default_nettype none
// Statistics table: per metric and per source shard it keeps count, sum, min, max and last
// sample. A record word (tuser 0) passes through accept, table read and table write back.
// A read word (tuser 1) does one table read and merge per shard, then a radix-2 divider
// forms the mean, then the result register is loaded. A word with an invalid metric skips
// the table and the divider. Only one word is in flight; a finished result waits in the
// output register while the next word is taken. After reset a clearing pass writes each
// of the NUM_METRICS*NUM_SHARDS entries, during which in_tready stays low.
module sharded_sample_stats_table #(
  parameter int NUM_SHARDS  = ssst_pkg::DEF_NUM_SHARDS,
  parameter int NUM_METRICS = ssst_pkg::DEF_NUM_METRICS
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // metric_index[7:0], source_core[10:8], sample[74:11], zero pad
  input  wire  [ssst_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // total_count, total_sum, smallest, largest, mean, latest (64 bits each)
  output logic [ssst_pkg::OUT_DATA_W-1:0] out_tdata,
  // ok[0], nonempty[1]
  output logic [1:0]                      out_tuser
);
  import ssst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  ssst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ssst_dp #(
    .NUM_SHARDS  (NUM_SHARDS),
    .NUM_METRICS (NUM_METRICS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: bench/sharded_sample_stats_table_tb.sv
`default_nettype none
module sharded_sample_stats_table_tb;
  import ssst_pkg::*;

  localparam int SHARDS  = DEF_NUM_SHARDS;
  localparam int METRICS = DEF_NUM_METRICS;
  localparam int DEPTH   = SHARDS * METRICS;
  localparam int N_RAND  = 450;

  typedef struct packed {
    logic        ok;
    logic        nonempty;
    logic [63:0] count;
    logic [63:0] sum;
    logic [63:0] mn;
    logic [63:0] mx;
    logic [63:0] mean;
    logic [63:0] last;
  } stats_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  metric;
    logic [2:0]  core;
    logic [63:0] smp;
    logic        chk;
    stats_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  sharded_sample_stats_table #(.NUM_SHARDS(SHARDS), .NUM_METRICS(METRICS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial forever #5 clk = ~clk;

  logic [63:0] tbl_count [DEPTH];
  logic [63:0] tbl_sum   [DEPTH];
  logic signed [63:0] tbl_min [DEPTH];
  logic signed [63:0] tbl_max [DEPTH];
  logic [63:0] tbl_last  [DEPTH];

  stats_t pending_stats[$];
  int errors = 0;
  bit stim_done = 0;
  int rx_cyc = 0;

  function automatic stats_t merge_stats(input logic [7:0] metric);
    stats_t r;
    logic signed [63:0] mn, mx, d, n;
    int idx;
    r = '0;
    mn = SMP_MAX;
    mx = SMP_MIN;
    if (metric >= METRICS) return r;
    r.ok = 1'b1;
    for (int s = 0; s < SHARDS; s++) begin
      idx = metric * SHARDS + s;
      if (tbl_count[idx] != 0) begin
        r.count += tbl_count[idx];
        r.sum += tbl_sum[idx];
        if (tbl_min[idx] < mn) mn = tbl_min[idx];
        if (tbl_max[idx] > mx) mx = tbl_max[idx];
        r.last = tbl_last[idx];
        r.nonempty = 1'b1;
      end
    end
    if (r.nonempty) begin
      r.mn = mn;
      r.mx = mx;
      d = r.count;
      n = r.sum;
      if (d == 0) r.mean = '0;
      else if (d == -1) r.mean = -r.sum;
      else r.mean = n / d;
    end
    return r;
  endfunction

  task automatic apply_word(input logic cmd, input logic [7:0] metric, input logic [2:0] core,
                            input logic [63:0] smp);
    int idx;
    if (cmd == CMD_READ) begin
      pending_stats.push_back(merge_stats(metric));
    end else if (metric < METRICS) begin
      idx = metric * SHARDS + ((core >= SHARDS) ? 0 : core);
      tbl_count[idx] += 1;
      tbl_sum[idx] += smp;
      tbl_last[idx] = smp;
      if ($signed(smp) < tbl_min[idx]) tbl_min[idx] = smp;
      if ($signed(smp) > tbl_max[idx]) tbl_max[idx] = smp;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_word(input logic cmd, input logic [7:0] metric, input logic [2:0] core,
                           input logic [63:0] smp);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {5'b0, smp, core, metric};
    do @(posedge clk); while (!in_tready);
    apply_word(cmd, metric, core, smp);
  endtask

  task automatic maybe_gap();
    int g;
    if ($urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return {$urandom, $urandom};
      3: return 64'($signed($urandom_range(0, 200)) - 100);
      default: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
    endcase
  endfunction

  row_t rows[] = '{
    '{CMD_READ,   8'd0,   3'd0, 64'd0, 1'b1, '{1, 0, 0, 0, 0, 0, 0, 0}},
    '{CMD_READ,   8'd16,  3'd0, 64'd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{CMD_READ,   8'd255, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{CMD_RECORD, 8'd0,   3'd0, SMP_MAX, 1'b0, '0},
    '{CMD_READ,   8'd0,   3'd0, 64'd0, 1'b1, '{1, 1, 1, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX,
                                                SMP_MAX}},
    '{CMD_RECORD, 8'd1,   3'd1, SMP_MIN, 1'b0, '0},
    '{CMD_READ,   8'd1,   3'd0, 64'd0, 1'b1, '{1, 1, 1, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN,
                                                SMP_MIN}},
    // core out of range lands in shard 0
    '{CMD_RECORD, 8'd2,   3'd7, 64'd5, 1'b0, '0},
    '{CMD_RECORD, 8'd2,   3'd1, -64'sd9, 1'b0, '0},
    '{CMD_READ,   8'd2,   3'd0, 64'd0, 1'b0, '0},
    '{CMD_RECORD, 8'd2,   3'd4, 64'd2, 1'b0, '0},
    '{CMD_READ,   8'd2,   3'd0, 64'd0, 1'b0, '0},
    // ignored record on an invalid metric
    '{CMD_RECORD, 8'd200, 3'd0, 64'd77, 1'b0, '0},
    '{CMD_RECORD, 8'd15,  3'd1, SMP_MAX, 1'b0, '0},
    '{CMD_RECORD, 8'd15,  3'd1, SMP_MAX, 1'b0, '0},
    '{CMD_RECORD, 8'd15,  3'd0, SMP_MIN, 1'b0, '0},
    '{CMD_READ,   8'd15,  3'd5, 64'h1234, 1'b0, '0},
    '{CMD_READ,   8'd3,   3'd0, 64'd0, 1'b1, '{1, 0, 0, 0, 0, 0, 0, 0}}
  };

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tbl_count[i] = 0; tbl_sum[i] = 0; tbl_min[i] = SMP_MAX;
      tbl_max[i] = SMP_MIN; tbl_last[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      send_word(rows[i].cmd, rows[i].metric, rows[i].core, rows[i].smp);
      if (rows[i].chk && rows[i].cmd == CMD_READ) pending_stats[$] = rows[i].want;
      maybe_gap();
    end
    for (int k = 0; k < N_RAND; k++) begin
      logic cmd;
      logic [7:0] metric;
      cmd = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_RECORD;
      metric = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      send_word(cmd, metric, 3'($urandom), rand_sample());
      if ($urandom_range(0, 7) == 0) maybe_gap();
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls, one long hold-off while the sender keeps pushing
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc >= 2000 && rx_cyc < 2500) out_tready <= 1'b0;
    else if (($time / 800) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    stats_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[63:0], '0);
      end else begin
        w = pending_stats.pop_front();
        if (out_tuser[0] !== w.ok) report_mismatch("ok", out_tuser[0], w.ok);
        if (out_tuser[1] !== w.nonempty) report_mismatch("nonempty", out_tuser[1], w.nonempty);
        if (out_tdata[63:0] !== w.count) report_mismatch("count", out_tdata[63:0], w.count);
        if (out_tdata[127:64] !== w.sum) report_mismatch("sum", out_tdata[127:64], w.sum);
        if (out_tdata[191:128] !== w.mn) report_mismatch("min", out_tdata[191:128], w.mn);
        if (out_tdata[255:192] !== w.mx) report_mismatch("max", out_tdata[255:192], w.mx);
        if (out_tdata[319:256] !== w.mean) report_mismatch("mean", out_tdata[319:256], w.mean);
        if (out_tdata[383:320] !== w.last) report_mismatch("last", out_tdata[383:320], w.last);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
